// ----- rtl/aup_pkg.sv -----
// ----------------------------------------------------------------------------
// aup_pkg
// Shared types and character constants for the ASCII unsigned integer parser.
// ----------------------------------------------------------------------------
package aup_pkg;

    localparam int unsigned BASE_W  = 6;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned OUT_W   = 88;   // 86 payload bits padded to bytes

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    // offsets that map a character onto its digit value
    localparam logic [CHAR_W-1:0] OFS_UP   = 8'h37;   // 'A' - 10
    localparam logic [CHAR_W-1:0] OFS_LO   = 8'h57;   // 'a' - 10

    localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
    localparam logic [BASE_W-1:0] BASE_DETECT = 6'd0;
    localparam logic [BASE_W-1:0] BASE_RST = BASE_DEC;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_ZERO0  = 3'd1,
        PH_HEX0   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic              is_ws;
        logic              is_nul;
        logic              is_zero;
        logic              is_x;
        logic              is_alnum;
        logic [BASE_W-1:0] digit_val;
    } t_char_class;

endpackage

// ----- rtl/aup_char_decode.sv -----
// ----------------------------------------------------------------------------
// aup_char_decode
// Classifies one character and gives its digit value.
// ----------------------------------------------------------------------------
module aup_char_decode
    import aup_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    output t_char_class       o_class
);

    logic is_num;
    logic is_up;
    logic is_lo;
    logic [CHAR_W-1:0] w_val;

    assign is_num = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_up  = (i_char >= CH_UP_A) && (i_char <= CH_UP_Z);
    assign is_lo  = (i_char >= CH_LO_A) && (i_char <= CH_LO_Z);

    always_comb begin
        if (is_num) begin
            w_val = i_char - CH_ZERO;
        end else if (is_up) begin
            w_val = i_char - OFS_UP;
        end else begin
            w_val = i_char - OFS_LO;
        end
    end

    assign o_class.is_ws     = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
    assign o_class.is_nul    = (i_char == CH_NUL);
    assign o_class.is_zero   = (i_char == CH_ZERO);
    assign o_class.is_x      = (i_char == CH_UP_X) || (i_char == CH_LO_X);
    assign o_class.is_alnum  = is_num || is_up || is_lo;
    assign o_class.digit_val = w_val[BASE_W-1:0];

endmodule

// ----- rtl/aup_parse_core.sv -----
// ----------------------------------------------------------------------------
// aup_parse_core
// Parse state, digit multiply-add and result register.
// ----------------------------------------------------------------------------
module aup_parse_core
    import aup_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_last,
    input  t_char_class        i_class,
    input  logic [BASE_W-1:0]  i_number_base,
    input  logic               i_res_ready,
    output logic               o_res_free,
    output logic               o_res_valid,
    output logic [VALUE_W-1:0] o_value,
    output logic [COUNT_W-1:0] o_count,
    output logic [BASE_W-1:0]  o_base
);

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               r_res_valid;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    logic [COUNT_W-1:0] r_res_count, n_res_count;
    logic [BASE_W-1:0]  r_res_base, n_res_base;

    logic               w_inc;
    logic               w_take;
    logic [BASE_W-1:0]  w_take_base;
    logic [BASE_W-1:0]  w_dflt_base;
    logic [VALUE_W-1:0] w_prod;
    logic               w_done_str;

    assign w_dflt_base = (i_number_base == BASE_DETECT) ? BASE_DEC : i_number_base;
    assign w_prod      = r_acc * VALUE_W'(w_take_base);
    assign w_done_str  = i_fire && i_last;

    // next parse state
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_base      = r_base;
        w_inc       = 1'b0;
        w_take      = 1'b0;
        w_take_base = r_base;
        unique case (r_phase)
            PH_SKIP: begin
                if (i_class.is_ws) begin
                    w_inc = 1'b1;
                end else if (i_class.is_nul) begin
                    n_base  = w_dflt_base;
                    n_phase = PH_DONE;
                end else if (i_number_base == BASE_DETECT) begin
                    if (i_class.is_zero) begin
                        n_base  = BASE_OCT;
                        w_inc   = 1'b1;
                        n_phase = PH_ZERO0;
                    end else begin
                        n_base      = BASE_DEC;
                        w_take      = 1'b1;
                        w_take_base = BASE_DEC;
                    end
                end else if (i_number_base == BASE_HEX && i_class.is_zero) begin
                    n_base  = BASE_HEX;
                    w_inc   = 1'b1;
                    n_phase = PH_HEX0;
                end else begin
                    n_base      = i_number_base;
                    w_take      = 1'b1;
                    w_take_base = i_number_base;
                end
            end
            PH_ZERO0: begin
                if (i_class.is_x) begin
                    n_base  = BASE_HEX;
                    w_inc   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    w_take = 1'b1;
                end
            end
            PH_HEX0: begin
                if (i_class.is_x) begin
                    w_inc   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    w_take = 1'b1;
                end
            end
            PH_DIGITS: begin
                w_take = 1'b1;
            end
            default: begin
            end
        endcase

        if (w_take) begin
            if (!i_class.is_alnum || (i_class.digit_val >= w_take_base)) begin
                n_phase = PH_DONE;
            end else begin
                n_acc   = w_prod + VALUE_W'(i_class.digit_val);
                w_inc   = 1'b1;
                n_phase = PH_DIGITS;
            end
        end

        n_count = (w_inc && (r_count != COUNT_MAX)) ? r_count + 1'b1 : r_count;
    end

    // result word
    always_comb begin
        n_res_value = n_acc;
        n_res_count = n_count;
        n_res_base  = (n_phase == PH_SKIP) ? w_dflt_base : n_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
            r_base  <= '0;
            r_count <= '0;
        end else if (w_done_str) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
            r_base  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_done_str) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_str) begin
            r_res_value <= n_res_value;
            r_res_count <= n_res_count;
            r_res_base  <= n_res_base;
        end
    end

    assign o_res_free  = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_value     = r_res_value;
    assign o_count     = r_res_count;
    assign o_base      = r_res_base;

    // a finished string always leaves a result and a clean parse state
    a_res_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_str |=> r_res_valid)
        else $error("result not loaded at end of string");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_str |=> (r_phase == PH_SKIP) && (r_count == '0) && (r_acc == '0))
        else $error("parse state not cleared after string");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_done_str |=> r_count >= $past(r_count))
        else $error("consumed count went backwards");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) && !w_done_str |=> (r_phase == PH_DONE) && $stable(r_acc))
        else $error("parser left done phase inside a string");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_str |-> o_res_free)
        else $error("result overwritten before taken");

endmodule

// ----- rtl/ascii_unsigned_integer_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_unsigned_integer_parser
// Streams characters in, returns one parsed unsigned value per string.
//
// Channel    Dir  Content
// s_axis     in   tdata[7:0] char_code, tlast last_char
// m_axis     out  tdata parsed_value / consumed_count / effective_base
// i_cfg_wr   in   number_base (6 bits, reset 10)
//
// One character per cycle while the input is not stalled; each passes through
// the input register, then the parse state / multiply-add into the result
// register. Reset is synchronous and clears parse state, base = 10.
// Input stalls only when a final character meets a full, unready result.
// ----------------------------------------------------------------------------
module ascii_unsigned_integer_parser
    import aup_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,   // last_char

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // [63:0] parsed_value, [79:64] consumed_count,
                                               // [85:80] effective_base, [87:86] zero

    input  logic               i_cfg_wr_en,
    input  logic [BASE_W-1:0]  i_cfg_wr_data
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic [BASE_W-1:0] r_number_base;

    t_char_class        w_class;
    logic               w_fire;
    logic               w_res_free;
    logic [VALUE_W-1:0] w_value;
    logic [COUNT_W-1:0] w_count;
    logic [BASE_W-1:0]  w_base;

    assign w_fire        = r_in_valid && (!r_in_last || w_res_free);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RST;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    aup_char_decode u_decode (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    aup_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_last        (r_in_last),
        .i_class       (w_class),
        .i_number_base (r_number_base),
        .i_res_ready   (m_axis_tready),
        .o_res_free    (w_res_free),
        .o_res_valid   (m_axis_tvalid),
        .o_value       (w_value),
        .o_count       (w_count),
        .o_base        (w_base)
    );

    assign m_axis_tdata = {2'b00, w_base, w_count, w_value};

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ASCII unsigned integer parser against a cycle-free predictor.
// A short opening table covers blanks, the zero byte, prefix detection, base
// one and the widest base, then random strings (mostly well-formed numbers
// with noise and broken ones mixed in) run under four pacing mixes.
// ----------------------------------------------------------------------------
module testbench;
    import aup_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] used;
        logic [BASE_W-1:0]  radix;
    } number_t;

    typedef struct packed {
        logic              wr_base;   // write base before this word
        logic [BASE_W-1:0] base;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;     // want holds the expected number
        number_t           want;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               i_cfg_wr_en = 1'b0;
    logic [BASE_W-1:0]  i_cfg_wr_data = '0;

    // predictor state
    t_phase             ph = PH_SKIP;
    logic [VALUE_W-1:0] acc = '0;
    logic [BASE_W-1:0]  act_base = '0;
    logic [COUNT_W-1:0] n_used = '0;
    logic [BASE_W-1:0]  radix = BASE_RST;

    number_t            numbers_due[$];
    logic [CHAR_W-1:0]  text[$];
    int                 mismatches = 0;
    int                 numbers_checked = 0;
    int                 chars_sent = 0;
    int                 send_idle = 0;
    int                 stall_pct = 0;

    stim_row_t directed_rows [25] = '{
        '{1'b0, 6'd0, CH_SPACE, 1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_TAB,   1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_LF,    1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_NINE,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_NINE,  1'b1, 1'b1, '{64'd99, 16'd5, BASE_DEC}},
        '{1'b0, 6'd0, CH_NUL,   1'b1, 1'b1, '{64'd0, 16'd0, BASE_DEC}},
        '{1'b0, 6'd0, 8'hFF,    1'b1, 1'b1, '{64'd0, 16'd0, BASE_DEC}},
        '{1'b0, 6'd0, CH_SPACE, 1'b1, 1'b1, '{64'd0, 16'd1, BASE_DEC}},
        '{1'b1, BASE_DETECT, CH_ZERO, 1'b1, 1'b1, '{64'd0, 16'd1, BASE_OCT}},
        '{1'b0, 6'd0, CH_ZERO,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_LO_X,  1'b1, 1'b1, '{64'd0, 16'd2, BASE_HEX}},
        '{1'b0, 6'd0, CH_ZERO,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_UP_X,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, "f",      1'b0, 1'b0, '0},
        '{1'b0, 6'd0, "F",      1'b1, 1'b1, '{64'd255, 16'd4, BASE_HEX}},
        '{1'b0, 6'd0, CH_ZERO,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, "7",      1'b0, 1'b0, '0},
        '{1'b0, 6'd0, "8",      1'b1, 1'b1, '{64'd7, 16'd2, BASE_OCT}},
        '{1'b1, 6'd1, CH_ZERO,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, "1",      1'b1, 1'b1, '{64'd0, 16'd1, 6'd1}},
        '{1'b1, 6'd63, CH_LO_Z, 1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_UP_Z,  1'b1, 1'b1, '{64'd2240, 16'd2, 6'd63}},
        '{1'b1, BASE_HEX, CH_ZERO, 1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_ZERO,  1'b0, 1'b0, '0},
        '{1'b0, 6'd0, CH_LO_A,  1'b1, 1'b0, '0}
    };

    ascii_unsigned_integer_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void bump_count();
        if (n_used != COUNT_MAX)
            n_used++;
    endfunction

    function automatic void absorb_digit(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] v;
        logic              ok;
        ok = 1'b1;
        v  = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            v = ch - CH_ZERO;
        else if (ch >= CH_UP_A && ch <= CH_UP_Z)
            v = ch - OFS_UP;
        else if (ch >= CH_LO_A && ch <= CH_LO_Z)
            v = ch - OFS_LO;
        else
            ok = 1'b0;
        if (ok && v < act_base) begin
            acc = acc * act_base + v;
            bump_count();
            ph = PH_DIGITS;
        end else begin
            ph = PH_DONE;
        end
    endfunction

    function automatic bit predict_char(input logic [CHAR_W-1:0] ch, input logic last,
                                        output number_t res);
        logic is_x;
        is_x = (ch == CH_LO_X || ch == CH_UP_X);
        res  = '0;
        case (ph)
            PH_SKIP: begin
                if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) begin
                    bump_count();
                end else if (ch == CH_NUL) begin
                    act_base = (radix == BASE_DETECT) ? BASE_DEC : radix;
                    ph = PH_DONE;
                end else if (radix == BASE_DETECT) begin
                    if (ch == CH_ZERO) begin
                        act_base = BASE_OCT;
                        bump_count();
                        ph = PH_ZERO0;
                    end else begin
                        act_base = BASE_DEC;
                        absorb_digit(ch);
                    end
                end else if (radix == BASE_HEX && ch == CH_ZERO) begin
                    act_base = BASE_HEX;
                    bump_count();
                    ph = PH_HEX0;
                end else begin
                    act_base = radix;
                    absorb_digit(ch);
                end
            end
            PH_ZERO0: begin
                if (is_x) begin
                    act_base = BASE_HEX;
                    bump_count();
                    ph = PH_DIGITS;
                end else begin
                    absorb_digit(ch);
                end
            end
            PH_HEX0: begin
                if (is_x) begin
                    bump_count();
                    ph = PH_DIGITS;
                end else begin
                    absorb_digit(ch);
                end
            end
            PH_DIGITS: absorb_digit(ch);
            default: ;
        endcase
        if (!last)
            return 1'b0;
        if (ph == PH_SKIP)
            act_base = (radix == BASE_DETECT) ? BASE_DEC : radix;
        res = '{acc, n_used, act_base};
        ph       = PH_SKIP;
        acc      = '0;
        act_base = '0;
        n_used   = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_number(input logic [OUT_W-1:0] word);
        number_t want;
        if (numbers_due.size() == 0) begin
            flag_mismatch($sformatf("number word %h with none due", word));
            return;
        end
        want = numbers_due.pop_front();
        numbers_checked++;
        if (word[63:0] !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d", word[63:0], want.value));
        if (word[79:64] !== want.used)
            flag_mismatch($sformatf("count %0d, want %0d", word[79:64], want.used));
        if (word[85:80] !== want.radix)
            flag_mismatch($sformatf("base %0d, want %0d", word[85:80], want.radix));
        if (word[87:86] !== 2'b00)
            flag_mismatch($sformatf("pad bits %b", word[87:86]));
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_number(m_axis_tdata);
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        number_t got;
        foreach (text[k]) begin
            send_char(text[k], k == text.size() - 1);
            if (predict_char(text[k], k == text.size() - 1, got))
                numbers_due.push_back(got);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (numbers_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_radix(input logic [BASE_W-1:0] b);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radix = b;
    endtask

    function automatic logic [BASE_W-1:0] pick_radix();
        case ($urandom_range(0, 9))
            0, 1:    return BASE_DETECT;
            2:       return BASE_OCT;
            3:       return BASE_DEC;
            4, 5:    return BASE_HEX;
            6:       return 6'd1;
            7:       return 6'd36;
            8:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
        if (v < 10)
            return 8'(CH_ZERO + v);
        return 8'((($urandom_range(0, 1) == 1) ? OFS_UP : OFS_LO) + v);
    endfunction

    // mostly well-formed numbers; some noise, zero bytes, blanks and broken digits
    function automatic void compose_text();
        int kind;
        int eff;
        int lim;
        int pos;
        text.delete();
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) text.push_back(blank_char());
        if (kind < 12) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
        end else if (kind < 16) begin
            text.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom));
        end else if (kind < 20) begin
            text.push_back(blank_char());
        end else begin
            eff = radix;
            if (radix == BASE_DETECT) begin
                case ($urandom_range(0, 2))
                    0: begin
                        text.push_back(CH_ZERO);
                        text.push_back(($urandom_range(0, 1) == 1) ? CH_LO_X : CH_UP_X);
                        eff = BASE_HEX;
                    end
                    1: begin
                        text.push_back(CH_ZERO);
                        eff = BASE_OCT;
                    end
                    default: begin
                        text.push_back(digit_char($urandom_range(1, 9)));
                        eff = BASE_DEC;
                    end
                endcase
            end else if (radix == BASE_HEX && $urandom_range(0, 1) == 1) begin
                text.push_back(CH_ZERO);
                text.push_back(($urandom_range(0, 1) == 1) ? CH_LO_X : CH_UP_X);
            end
            lim = (eff > 36) ? 36 : eff;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12))
                text.push_back(digit_char($urandom_range(0, lim - 1)));
            if (kind < 32) begin
                pos = $urandom_range(0, text.size() - 1);
                text.insert(pos, 8'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
        end
    endfunction

    task automatic run_phase(input int idle_in, input int stall_out, input int n_chars);
        int target;
        send_idle = idle_in;
        stall_pct = stall_out;
        target    = chars_sent + n_chars;
        while (chars_sent < target) begin
            if ($urandom_range(0, 5) == 0)
                set_radix(pick_radix());
            compose_text();
            send_text();
        end
        wait_drained();
    endtask

    initial begin
        number_t got;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].wr_base)
                set_radix(directed_rows[r].base);
            send_char(directed_rows[r].ch, directed_rows[r].last);
            if (predict_char(directed_rows[r].ch, directed_rows[r].last, got))
                numbers_due.push_back(directed_rows[r].typed ? directed_rows[r].want : got);
        end

        run_phase(0, 0, 400);
        run_phase(72, 0, 400);
        run_phase(0, 72, 400);
        run_phase(31, 31, 400);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d characters in, %0d numbers checked", chars_sent,
                 numbers_checked);
        $display("summary: bases 0 to 63, prefixes, blanks and noise, four pacing mixes");
        if (mismatches == 0 && numbers_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
